/* design/scp_pkg.sv */
package scp_pkg;

	localparam int ANGLE_W     = 32;
	localparam int RES_W       = 32;
	localparam int MAG_W       = 32;
	localparam int QUAD_W      = 15;
	localparam int REM_W       = 36;
	localparam int X2_W        = 33;
	localparam int RED_STAGES  = 4;
	localparam int POLY_STAGES = 5;
	localparam int NUM_STAGES  = RED_STAGES + POLY_STAGES + 1;

	// 2/pi in unsigned Q0.32
	localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
	// pi/2 in Q.32: 201/128 exact plus the small correction term
	localparam logic [32:0] HALF_PI_RAT_Q32  = 33'd6744440832;
	localparam logic [32:0] HALF_PI_CORR_Q32 = 33'd2078020;
	localparam logic [32:0] HALF_PI_Q32      = HALF_PI_RAT_Q32 + HALF_PI_CORR_Q32;

	// polynomial coefficients in Q2.30
	localparam logic signed [31:0] POLY_ONE = 32'sd1073741824;
	localparam logic signed [31:0] POLY_C1  = -32'sd178949812;
	localparam logic signed [31:0] POLY_C2  = 32'sd8927412;
	localparam logic signed [31:0] POLY_C3  = 32'sd199093;

	typedef logic signed [RES_W-1:0] q30_t;
	typedef logic [NUM_STAGES-1:0]   stage_vec_t;

	// round half up to Q2.30 from a Q4.60 product
	function automatic logic signed [34:0] rnd30(input logic signed [64:0] p);
		logic signed [64:0] s;
		s = p + 65'sd536870912;
		return 35'(s >>> 30);
	endfunction

endpackage

/* design/scp_reduce.sv */
module scp_reduce import scp_pkg::*; (
	input  logic                  clk,
	input  logic [RED_STAGES-1:0] en,
	input  logic [ANGLE_W-1:0]    angle,
	output q30_t                  sin_x_s4,
	output q30_t                  cos_x_s4,
	output logic                  neg_s4
);

	logic [MAG_W-1:0]         mag_s1, mag_s2;
	logic                     neg_s1, neg_s2, neg_s3;
	logic [QUAD_W-1:0]        quad_s2;
	logic [1:0]               quad_s3;
	logic signed [REM_W-1:0]  rem_s3;

	logic [63:0]              quad_prod;
	logic [47:0]              quad_half_pi;
	logic [47:0]              rem_diff;
	logic signed [REM_W-1:0]  rem_m, xr_full, xm_full;
	q30_t                     xr, xm, sin_x, cos_x;

	// stage 1: strip the sign
	always_ff @(posedge clk) begin
		if (en[0]) begin
			neg_s1 <= angle[ANGLE_W-1];
			mag_s1 <= angle[ANGLE_W-1] ? (~angle + 32'd1) : angle;
		end
	end

	// stage 2: quadrant count, truncated
	assign quad_prod = mag_s1 * TWO_OVER_PI_Q32;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			neg_s2  <= neg_s1;
			mag_s2  <= mag_s1;
			quad_s2 <= quad_prod[48+QUAD_W-1:48];
		end
	end

	// stage 3: exact remainder; the true value fits in REM_W bits
	assign quad_half_pi = quad_s2 * HALF_PI_Q32;
	assign rem_diff     = {mag_s2, 16'h0000} - quad_half_pi;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			neg_s3  <= neg_s2;
			quad_s3 <= quad_s2[1:0];
			rem_s3  <= signed'(rem_diff[REM_W-1:0]);
		end
	end

	// stage 4: shifted remainder, round to Q2.30, pick arguments
	always_comb begin
		rem_m   = rem_s3 - signed'(36'(HALF_PI_Q32));
		xr_full = (rem_s3 + 36'sd2) >>> 2;
		xm_full = (rem_m + 36'sd2) >>> 2;
		xr      = xr_full[RES_W-1:0];
		xm      = xm_full[RES_W-1:0];
		case (quad_s3)
			2'd0: begin
				sin_x = xr;
				cos_x = -xm;
			end
			2'd1: begin
				sin_x = -xm;
				cos_x = -xr;
			end
			2'd2: begin
				sin_x = -xr;
				cos_x = xm;
			end
			default: begin
				sin_x = xm;
				cos_x = xr;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			neg_s4   <= neg_s3;
			sin_x_s4 <= sin_x;
			cos_x_s4 <= cos_x;
		end
	end

endmodule

/* design/scp_poly.sv */
module scp_poly import scp_pkg::*; (
	input  logic                   clk,
	input  logic [POLY_STAGES-1:0] en,
	input  q30_t                   x,
	output q30_t                   y_s9
);

	logic signed [X2_W-1:0] x2_s5, x2_s6, x2_s7;
	q30_t                   x_s5, x_s6, x_s7, x_s8;
	q30_t                   a_s6, b_s7, c_s8;

	logic signed [64:0]     p5, p6, p7, p8, p9;
	logic signed [34:0]     r5, r6, r7, r8, r9;

	// Horner steps, one multiply per stage
	always_comb begin
		p5 = x * x;
		r5 = rnd30(p5);
		p6 = x2_s5 * POLY_C3;
		r6 = rnd30(p6);
		p7 = x2_s6 * a_s6;
		r7 = rnd30(p7);
		p8 = x2_s7 * b_s7;
		r8 = rnd30(p8);
		p9 = x_s8 * c_s8;
		r9 = rnd30(p9);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s5  <= x;
			x2_s5 <= r5[X2_W-1:0];
		end
		if (en[1]) begin
			x_s6  <= x_s5;
			x2_s6 <= x2_s5;
			a_s6  <= POLY_C2 - r6[RES_W-1:0];
		end
		if (en[2]) begin
			x_s7  <= x_s6;
			x2_s7 <= x2_s6;
			b_s7  <= POLY_C1 + r7[RES_W-1:0];
		end
		if (en[3]) begin
			x_s8 <= x_s7;
			c_s8 <= POLY_ONE + r8[RES_W-1:0];
		end
		if (en[4]) begin
			y_s9 <= r9[RES_W-1:0];
		end
	end

endmodule

/* design/sine_cosine_polynomial.sv */
// Fixed-point sine and cosine, one angle per transaction.
//
// Input channel: angle (signed Q16.16 radians) with in_valid / in_ready.
// Output channel: sine and cosine (signed Q2.30) with out_valid / out_ready.
// A transaction completes on a rising edge where valid and ready are both high.
//
// Throughput: one angle per cycle while out_ready is high. The result passes
// through ten register stages: sign strip, quadrant multiply, remainder
// multiply, argument select, five Horner multiply stages (sine and cosine
// lanes side by side) and the output register.
//
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it loads, so bubbles close up under a stall and in_ready stays
// high while any stage is free, even with a result waiting at the output.
// Stalls hold full stages with no gap after them; none is dropped or repeated.
//
// Reset clears all valid bits; the pipeline comes up empty and in_ready high.
module sine_cosine_polynomial import scp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ANGLE_W-1:0] angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [RES_W-1:0]   sine,
	output logic [RES_W-1:0]   cosine
);

	stage_vec_t vld_q;
	stage_vec_t en;

	q30_t sin_x_s4, cos_x_s4;
	q30_t sin_y_s9, cos_y_s9;
	q30_t sine_s10, cosine_s10;
	logic neg_s4, neg_s5, neg_s6, neg_s7, neg_s8, neg_s9;

	// load enables: a stage advances when empty or when its successor advances
	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign in_ready = en[0];

	// advance valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// range reduction: stages 1 to 4
	scp_reduce u_reduce (
		.clk      (clk),
		.en       (en[RED_STAGES-1:0]),
		.angle    (angle),
		.sin_x_s4 (sin_x_s4),
		.cos_x_s4 (cos_x_s4),
		.neg_s4   (neg_s4)
	);

	// odd polynomial lanes: stages 5 to 9
	scp_poly u_poly_sin (
		.clk  (clk),
		.en   (en[RED_STAGES+POLY_STAGES-1:RED_STAGES]),
		.x    (sin_x_s4),
		.y_s9 (sin_y_s9)
	);

	scp_poly u_poly_cos (
		.clk  (clk),
		.en   (en[RED_STAGES+POLY_STAGES-1:RED_STAGES]),
		.x    (cos_x_s4),
		.y_s9 (cos_y_s9)
	);

	// carry the input sign alongside the polynomial lanes
	always_ff @(posedge clk) begin
		if (en[4]) begin
			neg_s5 <= neg_s4;
		end
		if (en[5]) begin
			neg_s6 <= neg_s5;
		end
		if (en[6]) begin
			neg_s7 <= neg_s6;
		end
		if (en[7]) begin
			neg_s8 <= neg_s7;
		end
		if (en[8]) begin
			neg_s9 <= neg_s8;
		end
	end

	// output register: negate the sine for a negative angle
	always_ff @(posedge clk) begin
		if (en[NUM_STAGES-1]) begin
			sine_s10   <= neg_s9 ? -sin_y_s9 : sin_y_s9;
			cosine_s10 <= cos_y_s9;
		end
	end

	assign out_valid = vld_q[NUM_STAGES-1];
	assign sine      = sine_s10;
	assign cosine    = cosine_s10;

	// an empty output stage frees the whole chain
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[NUM_STAGES-1] |-> in_ready)
		else $error("in_ready low with output stage empty");

	// a taking receiver frees the whole chain
	a_taken_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("in_ready low while out_ready high");

	// a full pipeline facing a stalled receiver must refuse input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && !out_ready |-> !in_ready)
		else $error("input accepted into full stalled pipeline");

	// a stalled result survives to the next cycle
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vld_q[NUM_STAGES-2]) ||
		out_valid && vld_q[NUM_STAGES-2])
		else $error("stalled result lost");

endmodule
